// ===== src/altiw_pkg.sv =====
package altiw_pkg;

   localparam int MNEMONIC_COUNT = 57;

   localparam logic [2:0] PH_SKIP       = 3'd0;
   localparam logic [2:0] PH_MNEM       = 3'd1;
   localparam logic [2:0] PH_OPER       = 3'd2;
   localparam logic [2:0] PH_HEX        = 3'd3;
   localparam logic [2:0] PH_REG_DIGIT  = 3'd4;
   localparam logic [2:0] PH_REG_AFTER  = 3'd5;
   localparam logic [2:0] PH_REG_SUFFIX = 3'd6;
   localparam logic [2:0] PH_DONE       = 3'd7;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_LF    = 8'h0a;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_R     = 8'h72;
   localparam logic [7:0] CH_UNDER = 8'h5f;
   localparam logic [7:0] CH_ONE   = 8'h31;
   localparam logic [7:0] PROG_DATA = 8'hff;
   localparam logic [31:0] BAD_WORD = 32'hffffffff;

   // Mnemonic text, right-justified and zero-padded to seven characters.
   localparam logic [55:0] ROM_TEXT [MNEMONIC_COUNT] = '{
      "nop", "mov", "neg", "cmp", "add", "sub", "mul", "div", "mod", "and",
      "or", "xor", "not", "nand", "nor", "nxor", "inc", "dec", "shl", "shr",
      "hole", "hole", "hole", "hole", "lit", "lip", "hole", "hole", "hole",
      "hole", "hole", "hole", "cle", "ste", "cll", "stl", "clg", "stg", "clk",
      "stk", "new", "delete", "size", "self", "store", "load", "system", "il",
      "goto", "egoto", "lgoto", "nggoto", "ggoto", "nlgoto", "negoto", "kgoto",
      "data"
   };

   localparam logic [7:0] ROM_OP [MNEMONIC_COUNT] = '{
      8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09,
      8'h0a, 8'h0b, 8'h0c, 8'h0d, 8'h0e, 8'h0f, 8'h10, 8'h11, 8'h12, 8'h13,
      8'h14, 8'h15, 8'h16, 8'h17, 8'h18, 8'h19, 8'h1a, 8'h1b, 8'h1c, 8'h1d,
      8'h1e, 8'h1f, 8'h20, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27,
      8'h28, 8'h29, 8'h2a, 8'h2b, 8'h2c, 8'h2d, 8'h2e, 8'h2f, 8'h30, 8'h31,
      8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'hff
   };

   localparam logic [7:0] ROM_PROG [MNEMONIC_COUNT] = '{
      8'h00, 8'h0a, 8'h0a, 8'h0a, 8'h2a, 8'h2a, 8'h2a, 8'h2a, 8'h2a, 8'h2a,
      8'h2a, 8'h2a, 8'h0a, 8'h2a, 8'h2a, 8'h2a, 8'h0a, 8'h0a, 8'h2e, 8'h2e,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h0b, 8'h0b, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h0a, 8'h02, 8'h0a, 8'h02, 8'h2a, 8'h2a, 8'h03, 8'h00, 8'h0a, 8'h0a,
      8'h0a, 8'h0a, 8'h0a, 8'h0a, 8'h0a, 8'h0a, 8'hff
   };

   typedef struct packed {
      logic [2:0]                phase;
      logic [MNEMONIC_COUNT-1:0] mask;
      logic [2:0]                char_index;
      logic [31:0]               accum;
      logic [7:0]                prog;
      logic [5:0]                bit_pos;
      logic [31:0]               tok_val;
      logic [7:0]                tok_len;
      logic [3:0]                low_shift;
      logic                      fault;
      logic                      stopped;
   } parse_state_type;

   function automatic parse_state_type reset_state();
      parse_state_type s;
      s.phase      = PH_SKIP;
      s.mask       = '1;
      s.char_index = 3'd0;
      s.accum      = 32'd0;
      s.prog       = 8'd0;
      s.bit_pos    = 6'd8;
      s.tok_val    = 32'd0;
      s.tok_len    = 8'd0;
      s.low_shift  = 4'he;
      s.fault      = 1'b0;
      s.stopped    = 1'b0;
      return s;
   endfunction

   function automatic logic [2:0] rom_len(input int k);
      logic [2:0] n;
      n = 3'd0;
      for (int b = 0; b < 7; b++) begin
         if (ROM_TEXT[k][b*8 +: 8] != 8'h00) n = n + 3'd1;
      end
      return n;
   endfunction

   function automatic logic [7:0] rom_char(input int k, input logic [2:0] j);
      logic [2:0] pos;
      pos = rom_len(k) - 3'd1 - j;
      return ROM_TEXT[k][{pos, 3'b000} +: 8];
   endfunction

   function automatic logic [7:0] digit_of(input logic [7:0] c);
      return (c >= 8'h61) ? (c - 8'h57) : (c - 8'h30);
   endfunction

   function automatic parse_state_type fail_fn(input parse_state_type s);
      parse_state_type r;
      r = s;
      r.fault = 1'b1;
      r.phase = PH_DONE;
      return r;
   endfunction

   function automatic parse_state_type next_op(input parse_state_type s);
      parse_state_type r;
      r = s;
      if (!r.prog[1]) r.phase = PH_DONE;
      else if (r.bit_pos == 6'd32) r = fail_fn(r);
      else r.phase = PH_OPER;
      return r;
   endfunction

   function automatic parse_state_type place_fn(input parse_state_type s,
                                                input logic [31:0] v,
                                                input logic [5:0] adv);
      parse_state_type r;
      r = s;
      r.accum   = r.accum | (v << r.bit_pos[4:0]);
      r.bit_pos = r.bit_pos + adv;
      r.prog    = r.prog >> 2;
      return next_op(r);
   endfunction

   function automatic parse_state_type hex_fn(input parse_state_type s,
                                              input logic [7:0] c,
                                              input logic delim);
      parse_state_type r;
      logic [31:0] v;
      logic [15:0] h;
      r = s;
      v = s.tok_val;
      h = s.tok_val[15:0];
      if (!delim) begin
         if (r.tok_len != 8'hff) r.tok_len = r.tok_len + 8'd1;
         r.tok_val = {r.tok_val[27:0], 4'h0} | {24'h0, digit_of(c)};
      end else if (r.prog == PROG_DATA) begin
         if (r.tok_len == 8'd8) begin
            r.accum = {v[7:0], v[15:8], v[23:16], v[31:24]};
            r.phase = PH_DONE;
         end else begin
            r = fail_fn(r);
         end
      end else if (r.tok_len == 8'd2) begin
         r = place_fn(r, v, 6'd8);
      end else if (r.tok_len == 8'd4) begin
         r = place_fn(r, {16'h0, h[7:0], h[15:8]}, 6'd16);
      end else begin
         r = fail_fn(r);
      end
      return r;
   endfunction

endpackage

// ===== src/altiw_step.sv =====
module altiw_step (
   input  altiw_pkg::parse_state_type cur,
   input  logic [7:0]                 ch,
   output altiw_pkg::parse_state_type nxt
);

   logic       term;
   logic       delim;
   logic       found;
   logic [5:0] sel;
   logic       keep;
   logic [7:0] dig;

   assign term  = (ch == altiw_pkg::CH_NUL) || (ch == altiw_pkg::CH_LF);
   assign delim = term || (ch == altiw_pkg::CH_SPACE);
   assign dig   = altiw_pkg::digit_of(ch);

   always_comb begin
      nxt   = cur;
      found = 1'b0;
      sel   = 6'd0;
      keep  = 1'b0;
      unique case (cur.phase)
         altiw_pkg::PH_SKIP: begin
            nxt.phase = altiw_pkg::PH_MNEM;
         end
         altiw_pkg::PH_MNEM: begin
            if (delim) begin
               // Scan downward so that the lowest matching entry wins.
               for (int k = altiw_pkg::MNEMONIC_COUNT - 1; k >= 0; k--) begin
                  if (cur.mask[k] && altiw_pkg::rom_len(k) == cur.char_index) begin
                     found = 1'b1;
                     sel   = 6'(k);
                  end
               end
               if (!found) begin
                  nxt = altiw_pkg::fail_fn(cur);
               end else begin
                  nxt.accum   = {24'h0, altiw_pkg::ROM_OP[sel]};
                  nxt.prog    = altiw_pkg::ROM_PROG[sel];
                  nxt.bit_pos = 6'd8;
                  if (altiw_pkg::ROM_PROG[sel] == altiw_pkg::PROG_DATA) begin
                     nxt.tok_val = 32'd0;
                     nxt.tok_len = 8'd0;
                     nxt.phase   = altiw_pkg::PH_HEX;
                  end else begin
                     nxt = altiw_pkg::next_op(nxt);
                  end
               end
            end else begin
               for (int k = 0; k < altiw_pkg::MNEMONIC_COUNT; k++) begin
                  keep = (cur.char_index < altiw_pkg::rom_len(k)) &&
                         (altiw_pkg::rom_char(k, cur.char_index) == ch);
                  nxt.mask[k] = cur.mask[k] & keep;
               end
               if (cur.char_index != 3'd7) nxt.char_index = cur.char_index + 3'd1;
               if (nxt.mask == '0) nxt = altiw_pkg::fail_fn(nxt);
            end
         end
         altiw_pkg::PH_OPER: begin
            if (cur.prog[0]) begin
               nxt.tok_val = 32'd0;
               nxt.tok_len = 8'd0;
               nxt.phase   = altiw_pkg::PH_HEX;
               nxt = altiw_pkg::hex_fn(nxt, ch, delim);
            end else if (ch == altiw_pkg::CH_R) begin
               nxt.phase = altiw_pkg::PH_REG_DIGIT;
            end else begin
               nxt = altiw_pkg::fail_fn(cur);
            end
         end
         altiw_pkg::PH_HEX: begin
            nxt = altiw_pkg::hex_fn(cur, ch, delim);
         end
         altiw_pkg::PH_REG_DIGIT: begin
            if (term) begin
               nxt = altiw_pkg::fail_fn(cur);
            end else begin
               nxt.tok_val = {24'h0, dig[3:0], 4'h0};
               nxt.phase   = altiw_pkg::PH_REG_AFTER;
            end
         end
         altiw_pkg::PH_REG_AFTER: begin
            if (delim) begin
               nxt = altiw_pkg::place_fn(cur, cur.tok_val | 32'he, 6'd8);
            end else if (ch == altiw_pkg::CH_UNDER) begin
               nxt.low_shift = 4'he;
               nxt.tok_len   = 8'd0;
               nxt.phase     = altiw_pkg::PH_REG_SUFFIX;
            end else begin
               nxt = altiw_pkg::fail_fn(cur);
            end
         end
         altiw_pkg::PH_REG_SUFFIX: begin
            if (delim) begin
               if (cur.tok_len == 8'd0) nxt = altiw_pkg::fail_fn(cur);
               else nxt = altiw_pkg::place_fn(cur, cur.tok_val | {28'h0, cur.low_shift},
                                              6'd8);
            end else begin
               if (cur.tok_len != 8'hff) nxt.tok_len = cur.tok_len + 8'd1;
               nxt.low_shift = {cur.low_shift[2:0], ch == altiw_pkg::CH_ONE};
            end
         end
         altiw_pkg::PH_DONE: begin
            nxt = cur;
         end
         default: begin
            nxt = cur;
         end
      endcase
   end

endmodule

// ===== src/assembly_line_to_instruction_word.sv =====
// Assembles one source line, fed one character per transfer, into a 32-bit
// instruction word.
// Input channel: req_ch carries a character, req_line_end marks the last
// character of the line. A character can be taken on every clock cycle
// while req_stall is low. Result channel: one transfer per line, rsp_word
// and rsp_bad_line; a bad line gives all ones in rsp_word with rsp_bad_line
// set. The result of a line is registered in the output register; the
// parse state, the mnemonic match over all ROM entries and the end-of-line
// closing step are all combinational between the state registers and the
// output register. A second result register absorbs one line's result
// while the receiver stalls; only when both are full does req_stall rise,
// and it falls once the receiver takes a result.
// Reset (synchronous, active high) drops any partial line and any pending
// results; the next character is the first of a new line and is skipped.
module assembly_line_to_instruction_word (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_ch,
   input  logic        req_line_end,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_word,
   output logic        rsp_bad_line
);

   altiw_pkg::parse_state_type st_ff, st_in;
   altiw_pkg::parse_state_type step1, step2, step1_adj;

   logic [7:0]  ch_eff;
   logic        accept;
   logic        res_bad;
   logic [31:0] res_word;

   logic        out_valid_ff, out_valid_in;
   logic [31:0] out_word_ff, out_word_in;
   logic        out_bad_ff, out_bad_in;
   logic        skid_valid_ff, skid_valid_in;
   logic [31:0] skid_word_ff, skid_word_in;
   logic        skid_bad_ff, skid_bad_in;

   assign accept = req_valid && !req_stall;
   assign ch_eff = st_ff.stopped ? altiw_pkg::CH_NUL : req_ch;

   altiw_step u_step_char (
      .cur (st_ff),
      .ch  (ch_eff),
      .nxt (step1)
   );

   // Once the line ends, a single terminator step settles the outcome.
   altiw_step u_step_close (
      .cur (step1),
      .ch  (altiw_pkg::CH_NUL),
      .nxt (step2)
   );

   always_comb begin
      step1_adj = step1;
      step1_adj.stopped = st_ff.stopped || (ch_eff == altiw_pkg::CH_NUL) ||
                          (ch_eff == altiw_pkg::CH_LF);
   end

   assign res_bad  = step2.fault || (step2.phase != altiw_pkg::PH_DONE);
   assign res_word = res_bad ? altiw_pkg::BAD_WORD : step2.accum;

   always_comb begin
      st_in = st_ff;
      if (accept) st_in = req_line_end ? altiw_pkg::reset_state() : step1_adj;
   end

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_word_in   = out_word_ff;
      out_bad_in    = out_bad_ff;
      skid_valid_in = skid_valid_ff;
      skid_word_in  = skid_word_ff;
      skid_bad_in   = skid_bad_ff;
      if (skid_valid_ff) begin
         if (!rsp_stall) begin
            out_word_in   = skid_word_ff;
            out_bad_in    = skid_bad_ff;
            skid_valid_in = 1'b0;
         end
      end else if (out_valid_ff && rsp_stall) begin
         if (accept && req_line_end) begin
            skid_valid_in = 1'b1;
            skid_word_in  = res_word;
            skid_bad_in   = res_bad;
         end
      end else begin
         out_valid_in = accept && req_line_end;
         out_word_in  = res_word;
         out_bad_in   = res_bad;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff         <= altiw_pkg::reset_state();
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         st_ff         <= st_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_word_ff  <= out_word_in;
      out_bad_ff   <= out_bad_in;
      skid_word_ff <= skid_word_in;
      skid_bad_ff  <= skid_bad_in;
   end

   assign req_stall    = skid_valid_ff;
   assign rsp_valid    = out_valid_ff;
   assign rsp_word     = out_word_ff;
   assign rsp_bad_line = out_bad_ff;

   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register holds a result while the output register is empty");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_bad_line) |-> (rsp_word == altiw_pkg::BAD_WORD))
      else $error("bad line result without the all-ones word");

   assert property (@(posedge clock) disable iff (reset)
      (accept && req_line_end) |=> (st_ff.phase == altiw_pkg::PH_SKIP && !st_ff.fault))
      else $error("parse state not restarted after the end of a line");

endmodule
